/* rtl/occupancy_grid_ray_march_core_defines.svh */
// ----------------------------------------------------------------------------
// Occupancy grid ray march: assertion macros
// Shared assertion helpers for the ray march core. Each macro expects clk
// and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_MARCH_CORE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_MARCH_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define OGRM_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ogrm: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define OGRM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ogrm: next-cycle check failed");

`else

`define OGRM_ASSERT_IMPLY(name, ante, cons)
`define OGRM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* rtl/ogrm_pkg.sv */
// ----------------------------------------------------------------------------
// Occupancy grid ray march package
// Shared types and fixed constants of the ray march core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ogrm_pkg;

  // Register map, indexed by paddr[3:2].
  localparam int          APB_AW              = 4;
  localparam logic [1:0]  REG_CELLS_PER_METER = 2'd0;
  localparam logic [1:0]  REG_GRID_COLUMNS    = 2'd1;
  localparam logic [1:0]  REG_GRID_ROWS       = 2'd2;
  localparam logic [1:0]  REG_STEP_LENGTH     = 2'd3;

  // Register reset values.
  localparam logic [7:0]  RST_CELLS_PER_METER = 8'd10;
  localparam logic [6:0]  RST_GRID_COLUMNS    = 7'd64;
  localparam logic [6:0]  RST_GRID_ROWS       = 7'd64;
  localparam logic [7:0]  RST_STEP_LENGTH     = 8'd26;

  // Width of the scaled position accumulators (position times map scale,
  // in 2^-24 cell units). Covers a start point at full range plus the
  // longest march at the largest step.
  localparam int          POS_W               = 42;

  // Shared multiplier operand and product widths.
  localparam int          MUL_W               = 18;
  localparam int          PROD_W              = 2 * MUL_W;

  // Sine polynomial coefficients, Q16.
  localparam logic signed [19:0] POLY_C0 = -20'sd307;
  localparam logic signed [19:0] POLY_C1 = 20'sd5223;
  localparam logic signed [19:0] POLY_C2 = -20'sd42334;
  localparam logic signed [19:0] POLY_C3 = 20'sd102944;

  // Control group from the sequencer to the grid store.
  typedef struct packed {
    logic wr_en;
    logic wr_bit;
    logic rd_en;
  } grid_cmd_t;

endpackage

`default_nettype wire

/* rtl/ogrm_grid.sv */
// ----------------------------------------------------------------------------
// Occupancy grid store
// One bit per cell, stored as GRID_H rows of GRID_W bits. A clearing pass
// zeroes one row per cycle after reset; reads are registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ogrm_grid #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ogrm_pkg::grid_cmd_t          cmd,
  input  wire  [$clog2(GRID_H)-1:0]    wr_row,
  input  wire  [$clog2(GRID_W)-1:0]    wr_col,
  input  wire  [$clog2(GRID_H)-1:0]    rd_row,
  input  wire  [$clog2(GRID_W)-1:0]    rd_col,
  output logic                         rd_bit,
  output logic                         busy
);

  localparam int ROW_W = $clog2(GRID_H);
  localparam int COL_W = $clog2(GRID_W);

  logic [GRID_W-1:0] grid_mem [GRID_H];
  logic [GRID_W-1:0] rd_data_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [ROW_W-1:0]  clr_row_r, clr_row_nxt;
  logic              busy_r, busy_nxt;

  // Clearing pass sequencing.
  always_comb begin
    clr_row_nxt = clr_row_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_row_nxt = clr_row_r + ROW_W'(1);
      if (clr_row_r == ROW_W'(GRID_H - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_row_r <= clr_row_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // Single write port: whole rows while clearing, single bits afterwards.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      grid_mem[clr_row_r] <= '0;
    end else if (cmd.wr_en) begin
      grid_mem[wr_row][wr_col] <= cmd.wr_bit;
    end
  end

  // Registered row read; the column is picked from the held row.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= grid_mem[rd_row];
      rd_col_r  <= rd_col;
    end
  end

  assign rd_bit = rd_data_r[rd_col_r];
  assign busy   = busy_r;

endmodule

`default_nettype wire

/* rtl/occupancy_grid_ray_march_core.sv */
// ----------------------------------------------------------------------------
// Occupancy grid ray march core
// Keeps a bit-per-cell occupancy grid and casts rays through it in fixed
// steps, reporting the distance to the first obstacle or the map edge.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one transaction per item. operation = 0 writes
//   one grid cell and produces no result. operation = 1 casts a ray and
//   produces exactly one out_ transaction (distance, hit). A ray first
//   evaluates sine and cosine with the shared 18x18 multiplier, then scales
//   the step and start point, then marches: each step passes a test state,
//   which checks the map bounds and issues the registered grid read, and a
//   read state, which checks the read bit and advances the position. The
//   march length is capped at MAX_STEPS steps. in_stall stays high for the
//   whole ray. The result sits in an output register, so a new transaction is
//   accepted while the previous result still waits under out_stall; a
//   finished ray waits in its last state until that register frees.
//   After reset the grid is cleared one row per cycle, during which in_stall
//   is high; configuration writes are taken anytime.
//   Registers on the APB port: cells_per_meter (0x0), grid_columns (0x4),
//   grid_rows (0x8), step_length (0xC).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "occupancy_grid_ray_march_core_defines.svh"

module occupancy_grid_ray_march_core #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int ANGLE_BITS = 12,
  parameter int MAX_STEPS  = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration port
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [ogrm_pkg::APB_AW-1:0]  cfg_paddr,
  input  wire  [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  // Input channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_operation,
  input  wire  [5:0]                   in_cell_col,
  input  wire  [5:0]                   in_cell_row,
  input  wire                          in_occupied,
  input  wire  [15:0]                  in_start_x,
  input  wire  [15:0]                  in_start_y,
  input  wire  [11:0]                  in_ray_angle,
  // Result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [15:0]                  out_distance,
  output logic                         out_hit
);

  localparam int ROW_W  = $clog2(GRID_H);
  localparam int COL_W  = $clog2(GRID_W);
  localparam int CNT_W  = $clog2(MAX_STEPS);
  localparam int AB     = ANGLE_BITS;
  localparam int ASH_L  = (AB >= 12) ? AB - 12 : 0;
  localparam int ASH_R  = (AB < 12) ? 12 - AB : 0;
  localparam int TSH    = 18 - AB;
  localparam int POS_W  = ogrm_pkg::POS_W;
  localparam int MUL_W  = ogrm_pkg::MUL_W;
  localparam int PROD_W = ogrm_pkg::PROD_W;

  localparam logic [AB-1:0] QTR   = AB'(1) << (AB - 2);
  localparam logic [AB-2:0] QTR_I = (AB - 1)'(1) << (AB - 2);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_TSET = 5'd1;
  localparam logic [4:0] S_TSQ  = 5'd2;
  localparam logic [4:0] S_M1   = 5'd3;
  localparam logic [4:0] S_A1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_A2   = 5'd6;
  localparam logic [4:0] S_M3   = 5'd7;
  localparam logic [4:0] S_A3   = 5'd8;
  localparam logic [4:0] S_M4   = 5'd9;
  localparam logic [4:0] S_A4   = 5'd10;
  localparam logic [4:0] S_SS   = 5'd11;
  localparam logic [4:0] S_MX   = 5'd12;
  localparam logic [4:0] S_MY   = 5'd13;
  localparam logic [4:0] S_X0   = 5'd14;
  localparam logic [4:0] S_Y0   = 5'd15;
  localparam logic [4:0] S_Y0B  = 5'd16;
  localparam logic [4:0] S_TEST = 5'd17;
  localparam logic [4:0] S_READ = 5'd18;
  localparam logic [4:0] S_EMIT = 5'd19;

  // Signed divide by 2^16 that truncates toward zero.
  function automatic logic signed [19:0] tdiv16(input logic signed [PROD_W-1:0] m);
    logic signed [PROD_W-1:0] b;
    b = m + (m[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    return b[PROD_W-1:16];
  endfunction

  // Configuration registers.
  logic [7:0] cpm_r;
  logic [6:0] cols_r;
  logic [6:0] rows_r;
  logic [7:0] step_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r  <= ogrm_pkg::RST_CELLS_PER_METER;
      cols_r <= ogrm_pkg::RST_GRID_COLUMNS;
      rows_r <= ogrm_pkg::RST_GRID_ROWS;
      step_r <= ogrm_pkg::RST_STEP_LENGTH;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        ogrm_pkg::REG_CELLS_PER_METER: cpm_r  <= cfg_pwdata[7:0];
        ogrm_pkg::REG_GRID_COLUMNS:    cols_r <= cfg_pwdata[6:0];
        ogrm_pkg::REG_GRID_ROWS:       rows_r <= cfg_pwdata[6:0];
        ogrm_pkg::REG_STEP_LENGTH:     step_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      ogrm_pkg::REG_CELLS_PER_METER: cfg_prdata = {24'd0, cpm_r};
      ogrm_pkg::REG_GRID_COLUMNS:    cfg_prdata = {25'd0, cols_r};
      ogrm_pkg::REG_GRID_ROWS:       cfg_prdata = {25'd0, rows_r};
      ogrm_pkg::REG_STEP_LENGTH:     cfg_prdata = {24'd0, step_r};
      default:                       cfg_prdata = '0;
    endcase
  end

  // A zero scale still tracks the sign of the position, so scale by one
  // and switch off the upper bound test and the cell mapping instead.
  logic       scale_zero;
  logic [7:0] scale_eff;

  assign scale_zero = (cpm_r == 8'd0);
  assign scale_eff  = scale_zero ? 8'd1 : cpm_r;

  // Sequencer and datapath registers.
  logic [4:0]              state_r, state_nxt;
  logic                    which_r, which_nxt;
  logic [CNT_W-1:0]        step_cnt_r, step_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             out_distance_r;
  logic                    out_hit_r;
  logic [15:0]             start_x_r, start_y_r;
  logic [AB-1:0]           ang_r;
  logic [16:0]             t_r;
  logic                    neg_r;
  logic [16:0]             t2_r;
  logic signed [MUL_W-1:0] p_r;
  logic signed [MUL_W-1:0] sin_r, cos_r;
  logic [15:0]             ss_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] dxs_r, dys_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic [15:0]             dist_r, dist_prev_r;
  logic [15:0]             res_dist_r;
  logic                    res_hit_r;
  logic                    cell_ok_r;

  // Grid store interface.
  ogrm_pkg::grid_cmd_t grid_cmd;
  logic [ROW_W-1:0]    grid_wr_row, grid_rd_row;
  logic [COL_W-1:0]    grid_wr_col, grid_rd_col;
  logic                grid_rd_bit;
  logic                grid_busy;

  ogrm_grid #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_grid (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (grid_cmd),
    .wr_row (grid_wr_row),
    .wr_col (grid_wr_col),
    .rd_row (grid_rd_row),
    .rd_col (grid_rd_col),
    .rd_bit (grid_rd_bit),
    .busy   (grid_busy)
  );

  // Input handshake.
  logic in_acc;

  assign in_stall = grid_busy || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Angle moved to ANGLE_BITS bits.
  logic [27:0]   ang_wide;
  logic [AB-1:0] ang_in;

  assign ang_wide = (28'(in_ray_angle) << ASH_L) >> ASH_R;
  assign ang_in   = ang_wide[AB-1:0];

  // Quarter-wave folding for sine (which_r = 0) or cosine (which_r = 1).
  logic [AB-1:0] ang_cur;
  logic [AB-3:0] ang_k;
  logic [AB-2:0] idx_cur;
  logic [16:0]   t_cur;

  assign ang_cur = which_r ? (ang_r + QTR) : ang_r;
  assign ang_k   = ang_cur[AB-3:0];
  assign idx_cur = ang_cur[AB-2] ? (QTR_I - {1'b0, ang_k}) : {1'b0, ang_k};
  assign t_cur   = 17'(idx_cur) << TSH;

  // Shared multiplier operand selection.
  logic signed [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TSQ: begin
        mul_a = {1'b0, t_r};
        mul_b = {1'b0, t_r};
      end
      S_M1: begin
        mul_a = MUL_W'(ogrm_pkg::POLY_C0);
        mul_b = {1'b0, prod_r[32:16]};
      end
      S_M2, S_M3: begin
        mul_a = p_r;
        mul_b = {1'b0, t2_r};
      end
      S_M4: begin
        mul_a = p_r;
        mul_b = {1'b0, t_r};
      end
      S_SS: begin
        mul_a = {10'd0, step_r};
        mul_b = {10'd0, scale_eff};
      end
      S_MX: begin
        mul_a = cos_r;
        mul_b = {2'd0, prod_r[15:0]};
      end
      S_MY: begin
        mul_a = sin_r;
        mul_b = {2'd0, ss_r};
      end
      S_X0: begin
        mul_a = {2'd0, start_x_r};
        mul_b = {10'd0, scale_eff};
      end
      S_Y0: begin
        mul_a = {2'd0, start_y_r};
        mul_b = {10'd0, scale_eff};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Polynomial accumulate and clamp of the finished sine value.
  logic signed [19:0]      prod_q;
  logic signed [MUL_W-1:0] sine_mag;

  assign prod_q = tdiv16(prod_r);

  always_comb begin
    if (prod_q[19]) begin
      sine_mag = '0;
    end else if (prod_q > 20'sd65536) begin
      sine_mag = MUL_W'(65536);
    end else begin
      sine_mag = prod_q[MUL_W-1:0];
    end
  end

  // Map test on the scaled position.
  logic signed [POS_W-1:0] xlim, ylim;
  logic                    off_map;
  logic [6:0]              cell_x, cell_y;
  logic                    cell_ok;
  logic                    cell_hit;
  logic [16:0]             dist_sum;
  logic [15:0]             dist_adv;
  logic                    at_cap;

  assign xlim    = $signed({{(POS_W - 31){1'b0}}, cols_r, 24'd0});
  assign ylim    = $signed({{(POS_W - 31){1'b0}}, rows_r, 24'd0});
  assign off_map = pos_x_r[POS_W-1] || pos_y_r[POS_W-1] ||
                   (!scale_zero && ((pos_x_r > xlim) || (pos_y_r > ylim)));
  assign cell_x  = scale_zero ? 7'd0 : pos_x_r[30:24];
  assign cell_y  = scale_zero ? 7'd0 : pos_y_r[30:24];
  assign cell_ok = (cell_x < GRID_W) && (cell_y < GRID_H);
  assign cell_hit = grid_rd_bit && cell_ok_r;

  // Distance advances by one step length, saturating.
  assign dist_sum = {1'b0, dist_r} + {9'd0, step_r};
  assign dist_adv = dist_sum[16] ? 16'hFFFF : dist_sum[15:0];
  assign at_cap   = (step_cnt_r == CNT_W'(MAX_STEPS - 1));

  // Grid commands: cell writes from idle, reads while marching.
  always_comb begin
    grid_cmd.wr_en  = in_acc && !in_operation &&
                      (in_cell_col < GRID_W) && (in_cell_row < GRID_H);
    grid_cmd.wr_bit = in_occupied;
    grid_cmd.rd_en  = (state_r == S_TEST) && !off_map;
    grid_wr_row     = ROW_W'(in_cell_row);
    grid_wr_col     = COL_W'(in_cell_col);
    grid_rd_row     = ROW_W'(cell_y);
    grid_rd_col     = COL_W'(cell_x);
  end

  // Sequencer next state.
  logic out_load;

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    which_nxt    = which_r;
    step_cnt_nxt = step_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_operation) begin
          state_nxt = S_TSET;
          which_nxt = 1'b0;
        end
      end
      S_TSET: state_nxt = S_TSQ;
      S_TSQ:  state_nxt = S_M1;
      S_M1:   state_nxt = S_A1;
      S_A1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_A2;
      S_A2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_A3;
      S_A3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_A4;
      S_A4: begin
        if (which_r) begin
          state_nxt = S_SS;
        end else begin
          state_nxt = S_TSET;
          which_nxt = 1'b1;
        end
      end
      S_SS:  state_nxt = S_MX;
      S_MX:  state_nxt = S_MY;
      S_MY:  state_nxt = S_X0;
      S_X0:  state_nxt = S_Y0;
      S_Y0:  state_nxt = S_Y0B;
      S_Y0B: begin
        state_nxt    = S_TEST;
        step_cnt_nxt = '0;
      end
      S_TEST: state_nxt = off_map ? S_EMIT : S_READ;
      S_READ: begin
        if (cell_hit || at_cap) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt    = S_TEST;
          step_cnt_nxt = step_cnt_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      which_r     <= 1'b0;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      which_r     <= which_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        start_x_r   <= in_start_x;
        start_y_r   <= in_start_y;
        ang_r       <= ang_in;
        dist_r      <= '0;
        dist_prev_r <= '0;
      end
      S_TSET: begin
        t_r   <= t_cur;
        neg_r <= ang_cur[AB-1];
      end
      S_M1: t2_r <= prod_r[32:16];
      S_A1: p_r  <= MUL_W'(ogrm_pkg::POLY_C1 + prod_q);
      S_A2: p_r  <= MUL_W'(ogrm_pkg::POLY_C2 + prod_q);
      S_A3: p_r  <= MUL_W'(ogrm_pkg::POLY_C3 + prod_q);
      S_A4: begin
        if (which_r) begin
          cos_r <= neg_r ? -sine_mag : sine_mag;
        end else begin
          sin_r <= neg_r ? -sine_mag : sine_mag;
        end
      end
      S_MX: ss_r  <= prod_r[15:0];
      S_MY: dxs_r <= prod_r;
      S_X0: dys_r <= prod_r;
      S_Y0: pos_x_r <= $signed({{(POS_W - 40){1'b0}}, prod_r[23:0], 16'd0});
      S_Y0B: begin
        // First step folded into the load of the start point.
        pos_y_r <= $signed({{(POS_W - 40){1'b0}}, prod_r[23:0], 16'd0})
                   - {{(POS_W - PROD_W){dys_r[PROD_W-1]}}, dys_r};
        pos_x_r <= pos_x_r + {{(POS_W - PROD_W){dxs_r[PROD_W-1]}}, dxs_r};
      end
      S_TEST: begin
        cell_ok_r  <= cell_ok;
        res_dist_r <= dist_prev_r;
        res_hit_r  <= 1'b0;
      end
      S_READ: begin
        if (cell_hit) begin
          res_dist_r <= dist_r;
          res_hit_r  <= 1'b1;
        end else if (at_cap) begin
          res_dist_r <= dist_adv;
          res_hit_r  <= 1'b0;
        end else begin
          pos_x_r     <= pos_x_r + {{(POS_W - PROD_W){dxs_r[PROD_W-1]}}, dxs_r};
          pos_y_r     <= pos_y_r - {{(POS_W - PROD_W){dys_r[PROD_W-1]}}, dys_r};
          dist_prev_r <= dist_r;
          dist_r      <= dist_adv;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_distance_r <= res_dist_r;
      out_hit_r      <= res_hit_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_hit      = out_hit_r;

  // Checks on the sequencer.
  `OGRM_ASSERT_IMPLY(a_no_accept_clearing, grid_busy, in_stall)
  `OGRM_ASSERT_IMPLY(a_read_after_test, state_r == S_READ, $past(state_r) == S_TEST)
  `OGRM_ASSERT_NEXT(a_hit_reported, (state_r == S_READ) && cell_hit,
                    (state_r == S_EMIT) && res_hit_r)

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Occupancy grid ray march core testbench
// Drives cell writes and ray casts into the core and checks each distance and
// hit flag against a cycle-free predictor of the march. Directed transactions
// cover obstacle hits, map exits, first-step exits, the step cap and zero or
// extreme register values. Random traffic then runs under several register
// settings and different patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int  GRID_W      = 64;
  localparam int  GRID_H      = 64;
  localparam int  MAX_STEPS   = 1024;
  localparam int  QUARTER     = 1024;
  localparam int  ANGLE_MASK  = 4095;
  localparam int  QUIET_LIMIT = 20000;
  localparam int  SETTLE      = 100;
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_RAY     = 1'b1;

  typedef struct packed {
    logic [15:0] distance;
    logic        hit;
  } ray_result_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [ogrm_pkg::APB_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [5:0]  in_cell_col  = '0;
  logic [5:0]  in_cell_row  = '0;
  logic        in_occupied  = 1'b0;
  logic [15:0] in_start_x   = '0;
  logic [15:0] in_start_y   = '0;
  logic [11:0] in_ray_angle = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_distance;
  logic        out_hit;

  // Predictor state: grid, registers and the quarter-wave sine table.
  bit          occupancy [0:GRID_W*GRID_H-1];
  longint      sine_quarter [0:QUARTER];
  int          map_scale;
  int          map_cols;
  int          map_rows;
  int          step_len;

  ray_result_t pending_results[$];
  ray_result_t want;
  int          errors       = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;

  occupancy_grid_ray_march_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_cell_col  (in_cell_col),
    .in_cell_row  (in_cell_row),
    .in_occupied  (in_occupied),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_ray_angle (in_ray_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_hit      (out_hit)
  );

  always #1 clk = ~clk;

  // Signed Q16 sine of a full-turn angle code, built from the quarter table.
  function automatic longint sine_of(input int angle);
    int a;
    int k;
    a = angle & ANGLE_MASK;
    k = a & (QUARTER - 1);
    case (a >> 10)
      0: return sine_quarter[k];
      1: return sine_quarter[QUARTER - k];
      2: return -sine_quarter[k];
      default: return -sine_quarter[QUARTER - k];
    endcase
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // March one ray through the predicted grid; position is in 2^-24 m.
  function automatic ray_result_t march_ray(input logic [15:0] sx, input logic [15:0] sy,
                                            input logic [11:0] angle);
    ray_result_t r;
    longint      x, y, dx, dy, xlim, ylim, cx, cy;
    int          i;
    dx   = sine_of(int'(angle) + QUARTER) * longint'(step_len);
    dy   = sine_of(int'(angle)) * longint'(step_len);
    x    = sx;
    y    = sy;
    x    = x <<< 16;
    y    = y <<< 16;
    xlim = longint'(map_cols) <<< 24;
    ylim = longint'(map_rows) <<< 24;
    for (i = 0; i < MAX_STEPS; i++) begin
      x = x + dx;
      y = y - dy;
      if (x < 0 || y < 0 || x * map_scale > xlim || y * map_scale > ylim) begin
        r.distance = (i == 0) ? 16'd0 : clamp16(longint'(step_len) * (i - 1));
        r.hit      = 1'b0;
        return r;
      end
      cx = (x * map_scale) >>> 24;
      cy = (y * map_scale) >>> 24;
      if (cx < GRID_W && cy < GRID_H && occupancy[int'(cy) * GRID_W + int'(cx)]) begin
        r.distance = clamp16(longint'(step_len) * i);
        r.hit      = 1'b1;
        return r;
      end
    end
    r.distance = clamp16(longint'(step_len) * MAX_STEPS);
    r.hit      = 1'b0;
    return r;
  endfunction

  // Send one transaction with random sender gaps ahead of it, then update the
  // predictor once the core takes it. Valid stays high on return.
  task automatic send_item(input logic op, input logic [5:0] col, input logic [5:0] row,
                           input logic occ, input logic [15:0] sx, input logic [15:0] sy,
                           input logic [11:0] angle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_cell_col  <= col;
    in_cell_row  <= row;
    in_occupied  <= occ;
    in_start_x   <= sx;
    in_start_y   <= sy;
    in_ray_angle <= angle;
    do @(posedge clk); while (in_stall);
    if (op == OP_WRITE) begin
      occupancy[int'(row) * GRID_W + int'(col)] = occ;
    end else begin
      pending_results = {pending_results, march_ray(sx, sy, angle)};
    end
  endtask

  task automatic cell_write(input int col, input int row, input bit occ);
    send_item(OP_WRITE, col[5:0], row[5:0], occ, 16'($urandom), 16'($urandom),
              12'($urandom));
  endtask

  task automatic cast_ray(input int sx, input int sy, input int angle);
    send_item(OP_RAY, 6'($urandom), 6'($urandom), 1'($urandom), sx[15:0], sy[15:0],
              angle[11:0]);
  endtask

  // Hold the sender off until every predicted result has come back, then let
  // the core settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      ogrm_pkg::REG_CELLS_PER_METER: map_scale = value & 8'hFF;
      ogrm_pkg::REG_GRID_COLUMNS:    map_cols  = value & 7'h7F;
      ogrm_pkg::REG_GRID_ROWS:       map_rows  = value & 7'h7F;
      default:                       step_len  = value & 8'hFF;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(input int scale, input int cols, input int rows,
                              input int step);
    drain_results();
    write_register(ogrm_pkg::REG_CELLS_PER_METER, scale);
    write_register(ogrm_pkg::REG_GRID_COLUMNS, cols);
    write_register(ogrm_pkg::REG_GRID_ROWS, rows);
    write_register(ogrm_pkg::REG_STEP_LENGTH, step);
  endtask

  // Obstacle hits and map exits at the reset register values.
  task automatic test_hits_and_exits();
    cast_ray(819, 819, 0);
    cell_write(40, 32, 1);
    cast_ray(832, 832, 0);
    cast_ray(832, 832, 2048);
    cell_write(0, 0, 1);
    cell_write(63, 63, 1);
    cast_ray(1600, 1600, 3584);
    cast_ray(0, 0, 2048);
    cast_ray(65535, 65535, 4095);
    cast_ray(819, 819, 1024);
    cast_ray(819, 819, 3072);
    cell_write(40, 32, 0);
    cast_ray(832, 832, 0);
  endtask

  // Step cap, zero step, zero scale and a map of zero extent.
  task automatic test_step_cap_and_zero_registers();
    apply_config(10, 64, 64, 1);
    cell_write(0, 0, 0);
    cast_ray(256, 819, 0);
    apply_config(10, 64, 64, 0);
    cell_write(5, 5, 1);
    cast_ray(141, 141, 1000);
    cast_ray(819, 819, 7);
    apply_config(0, 64, 64, 255);
    cast_ray(1000, 1000, 0);
    cast_ray(1000, 1000, 2048);
    cell_write(0, 0, 1);
    cast_ray(1000, 1000, 1024);
    cell_write(0, 0, 0);
    apply_config(10, 0, 0, 26);
    cast_ray(0, 0, 1024);
    cast_ray(0, 500, 0);
  endtask

  // Largest and smallest nonzero register values.
  task automatic test_register_extremes();
    apply_config(255, 127, 127, 255);
    cast_ray(60, 60, 512);
    cast_ray(10, 10, 3584);
    apply_config(1, 1, 1, 1);
    cast_ray(128, 128, 0);
    cast_ray(128, 128, 2048);
  endtask

  // Random mix of cell writes and rays; most rays start inside the map. The
  // sender pauses halfway until all results are back.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int n;
    int ext_x;
    int ext_y;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    ext_x = (map_scale == 0) ? 65535 : map_cols * 256 / map_scale;
    ext_y = (map_scale == 0) ? 65535 : map_rows * 256 / map_scale;
    if (ext_x > 65535) ext_x = 65535;
    if (ext_y > 65535) ext_y = 65535;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      if ($urandom_range(99) < 45) begin
        cell_write($urandom_range(63), $urandom_range(63), $urandom_range(99) < 40);
      end else if ($urandom_range(99) < 85) begin
        cast_ray($urandom_range(ext_x), $urandom_range(ext_y), $urandom_range(4095));
      end else begin
        cast_ray($urandom_range(65535), $urandom_range(65535), $urandom_range(4095));
      end
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  // Compare each result with the oldest prediction, then draw the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: distance %0d hit %0d", $time,
                 out_distance, out_hit);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_distance !== want.distance) begin
          $display("%0t: distance mismatch: expected %0d, actual %0d", $time,
                   want.distance, out_distance);
          errors++;
        end
        if (out_hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0d, actual %0d", $time, want.hit,
                   out_hit);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    longint t, t2, p;
    int     k;
    // Predictor reset: sine table, empty grid, register reset values.
    for (k = 0; k <= QUARTER; k++) begin
      t  = longint'(k) <<< 6;
      t2 = (t * t) / 65536;
      p  = -307;
      p  = 5223 + (p * t2) / 65536;
      p  = -42334 + (p * t2) / 65536;
      p  = 102944 + (p * t2) / 65536;
      p  = (p * t) / 65536;
      if (p < 0) p = 0;
      if (p > 65536) p = 65536;
      sine_quarter[k] = p;
    end
    for (k = 0; k < GRID_W * GRID_H; k++) occupancy[k] = 1'b0;
    map_scale = ogrm_pkg::RST_CELLS_PER_METER;
    map_cols  = ogrm_pkg::RST_GRID_COLUMNS;
    map_rows  = ogrm_pkg::RST_GRID_ROWS;
    step_len  = ogrm_pkg::RST_STEP_LENGTH;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_hits_and_exits();
    test_step_cap_and_zero_registers();
    test_register_extremes();

    apply_config(10, 64, 64, 26);
    test_random_traffic(170, 0, 0);
    apply_config(20, 40, 50, 13);
    test_random_traffic(170, 46, 0);
    apply_config(255, 127, 127, 255);
    test_random_traffic(170, 0, 46);
    apply_config(1, 64, 64, 255);
    test_random_traffic(170, 32, 32);
    apply_config($urandom_range(1, 255), $urandom_range(1, 127), $urandom_range(1, 127),
                 $urandom_range(8, 255));
    test_random_traffic(170, 32, 32);
    apply_config(10, 64, 64, 26);
    test_random_traffic(170, 46, 46);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
